// ===== design/udm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udm_pkg
// Shared types and field widths for the unsigned divide/modulo pipeline.
// ----------------------------------------------------------------------------
package udm_pkg;

	localparam int unsigned FIELD_W   = 32;
	localparam int unsigned S_TDATA_W = 2 * FIELD_W;
	localparam int unsigned M_TDATA_W = 2 * FIELD_W;

	// per-stage control that travels alongside the datapath
	typedef struct packed {
		logic valid;
		logic dz;
	} udm_ctl_t;

endpackage

// ===== design/udm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udm_cell
// One restoring division step: shift the partial remainder, take in the next
// dividend bit, subtract the divisor when it fits, register the result.
// ----------------------------------------------------------------------------
module udm_cell
	import udm_pkg::*;
#(
	parameter int unsigned W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  udm_ctl_t     ctl_in,
	input  logic [W-1:0] part_in,
	input  logic [W-1:0] num_in,
	input  logic [W-1:0] quot_in,
	input  logic [W-1:0] den_in,
	output udm_ctl_t     ctl_out,
	output logic [W-1:0] part_out,
	output logic [W-1:0] num_out,
	output logic [W-1:0] quot_out,
	output logic [W-1:0] den_out
);

	logic [W:0]   shifted;
	logic [W:0]   diff;
	logic         take;
	logic [W-1:0] part_nxt;

	udm_ctl_t     ctl_s1;
	logic [W-1:0] part_s1;
	logic [W-1:0] num_s1;
	logic [W-1:0] quot_s1;
	logic [W-1:0] den_s1;

	// carry out of the shift lands in the top bit, so the compare is exact
	assign shifted  = {part_in, num_in[W-1]};
	assign diff     = shifted - {1'b0, den_in};
	assign take     = ~diff[W];
	assign part_nxt = take ? diff[W-1:0] : shifted[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			part_s1 <= part_nxt;
			num_s1  <= {num_in[W-2:0], 1'b0};
			quot_s1 <= {quot_in[W-2:0], take};
			den_s1  <= den_in;
		end
	end

	assign ctl_out  = ctl_s1;
	assign part_out = part_s1;
	assign num_out  = num_s1;
	assign quot_out = quot_s1;
	assign den_out  = den_s1;

endmodule

// ===== design/unsigned_divide_modulo_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_divide_modulo_top
// Pipelined restoring divider giving quotient, remainder and a zero flag.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes operand pairs: s_tdata = {divisor, dividend}.
//   Master stream returns m_tdata = {remainder, quotient} and m_tuser, the
//   divide-by-zero flag. A zero divisor returns zero quotient and remainder.
//   Operands are taken at WORD_WIDTH bits; results are given at 32 bits.
//   The datapath is a chain of WORD_WIDTH cells, one quotient bit per cell,
//   each cell registered. A result passes through the register of every
//   cell in turn before it appears on the master side.
//   Throughput is one transfer per cycle while the output is not stalled; the cell chain sets the latency.
//   When the receiver stalls with a result waiting, the whole chain holds
//   and s_tready drops until that result is taken.
//   Reset clears all stage valid flags; nothing is in flight after reset.
// ----------------------------------------------------------------------------
module unsigned_divide_modulo_top
	import udm_pkg::*;
#(
	parameter int unsigned WORD_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // dividend_value[31:0], divisor_value[63:32]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // quotient[31:0], remainder[63:32]
	output logic                 m_tuser   // divide_by_zero
);

	localparam int unsigned W = WORD_WIDTH;

	logic            en;
	logic [W-1:0]    dividend_w;
	logic [W-1:0]    divisor_w;
	udm_ctl_t        ctl_a  [0:W];
	logic [W-1:0]    part_a [0:W];
	logic [W-1:0]    num_a  [0:W];
	logic [W-1:0]    quot_a [0:W];
	logic [W-1:0]    den_a  [0:W];
	logic [FIELD_W-1:0] quot_f;
	logic [FIELD_W-1:0] rem_f;

	// advance the whole chain whenever the output slot is free or drained
	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;

	assign dividend_w = W'(s_tdata[FIELD_W-1:0]);
	assign divisor_w  = W'(s_tdata[S_TDATA_W-1:FIELD_W]);

	assign ctl_a[0].valid = s_tvalid;
	assign ctl_a[0].dz    = (divisor_w == '0);
	assign part_a[0]      = '0;
	assign num_a[0]       = dividend_w;
	assign quot_a[0]      = '0;
	assign den_a[0]       = divisor_w;

	for (genvar i = 0; i < W; i++) begin : g_cell
		udm_cell #(
			.W(W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (ctl_a[i]),
			.part_in (part_a[i]),
			.num_in  (num_a[i]),
			.quot_in (quot_a[i]),
			.den_in  (den_a[i]),
			.ctl_out (ctl_a[i+1]),
			.part_out(part_a[i+1]),
			.num_out (num_a[i+1]),
			.quot_out(quot_a[i+1]),
			.den_out (den_a[i+1])
		);
	end

	// drop the loop result on a zero divisor
	assign quot_f = ctl_a[W].dz ? '0 : FIELD_W'(quot_a[W]);
	assign rem_f  = ctl_a[W].dz ? '0 : FIELD_W'(part_a[W]);

	assign m_tvalid = ctl_a[W].valid;
	assign m_tdata  = {rem_f, quot_f};
	assign m_tuser  = ctl_a[W].dz;

endmodule

// ===== design/udm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udm_checker
// Port-level checks for the divider, bound to the top level.
// ----------------------------------------------------------------------------
module udm_checker
	import udm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser
);

	// a stalled result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// zero divisor reports zero quotient and remainder
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("divide-by-zero result not cleared");

	// input side advances exactly when the output slot is free or being drained
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output slot");

	// no result is offered while reset is held
	a_rst: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid || arst_n)
		else $error("result valid during reset");

endmodule

bind unsigned_divide_modulo_top udm_checker u_udm_checker (.*);
